@@ design/xlb_pkg.sv @@
// xlb_pkg: types and constants shared by the XOR linear basis block.
// Used by xlb_cell and xor_linear_basis. No dependencies.

package xlb_pkg;

    // Width of the values kept in the basis (2..63)
    localparam int VALUE_BITS = 63;
    // One basis slot per possible leading bit
    localparam int DEPTH      = VALUE_BITS;
    // Entry count, wide enough to hold DEPTH itself
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths fixed by the port definition
    localparam int FIELD_W    = 63;
    localparam int SIZE_W     = 6;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      count_t;

    // Operation codes carried on the request func field
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_REDUCE = 2'd1,
        FN_CLEAR  = 2'd2
    } func_t;

    // Request payload
    typedef struct packed {
        logic [1:0]         func;
        logic [FIELD_W-1:0] value;
    } req_t;

    // Response payload
    typedef struct packed {
        logic [FIELD_W-1:0] reduced;
        logic               inserted;
        logic [SIZE_W-1:0]  basis_size;
        logic [FIELD_W-1:0] max_xor;
    } rsp_t;

    // Token handed from cell to cell along the chain
    typedef struct packed {
        logic   vld;
        func_t  op;
        value_t v;      // value being reduced
        value_t acc;    // running greedy maximum
        logic   ins;    // set by the cell that stored the remainder
    } tok_t;

endpackage

@@ design/xor_linear_basis.sv @@
// xor_linear_basis: top level, a chain of DEPTH basis cells plus the entry
// count and the response register. Depends on xlb_pkg and xlb_cell.

// Each request walks the full chain of DEPTH cells (63 at the default width),
// one cell per cycle unless the chain stalls, and its result then moves into
// the response register. One request is in the chain at a time: the next one
// is taken once the previous result has moved into the response register, so
// a new request is not accepted before the previous one has left the chain.
// The response register holds a finished result while the next request
// already travels the chain. Insert appends a nonzero remainder at the end of
// the basis; clear empties it and returns all zero fields.

module xor_linear_basis
    import xlb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    tok_t   chain [0:DEPTH];
    tok_t   tail;
    logic   adv;
    logic   load_out;
    logic   req_xfer;

    logic   busy_reg;
    logic   busy_next;
    count_t count_reg;
    count_t count_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    rsp_t   out_reg;
    rsp_t   out_next;
    count_t size_new;

    assign req_ready = !busy_reg;
    assign req_xfer  = req_valid && req_ready;

    // Head token built from the request
    always_comb
    begin
        chain[0].vld = req_xfer;
        chain[0].v   = req_data.value[VALUE_BITS-1:0];
        chain[0].acc = '0;
        chain[0].ins = 1'b0;
        case (req_data.func)
            FN_INSERT: chain[0].op = FN_INSERT;
            FN_CLEAR:  chain[0].op = FN_CLEAR;
            default:   chain[0].op = FN_REDUCE;
        endcase
    end

    // Row of basis cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            xlb_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .idx     (CNT_W'(gi)),
                .count   (count_reg),
                .tok_in  (chain[gi]),
                .tok_out (chain[gi+1])
            );
        end
    endgenerate

    assign tail = chain[DEPTH];

    // Chain stalls only when a finished token meets a full response register that is not being taken
    assign adv      = !tail.vld || !out_valid_reg || rsp_ready;
    assign load_out = tail.vld && adv;

    // Result fields and the count after this operation
    always_comb
    begin
        size_new   = count_reg + CNT_W'(tail.ins);
        count_next = count_reg;
        out_next   = out_reg;
        if (load_out)
        begin
            if (tail.op == FN_CLEAR)
            begin
                count_next = '0;
                out_next   = '0;
            end
            else
            begin
                count_next          = size_new;
                out_next.reduced    = FIELD_W'(tail.v);
                out_next.inserted   = tail.ins;
                out_next.basis_size = SIZE_W'(size_new);
                out_next.max_xor    = FIELD_W'(tail.acc);
            end
        end
    end

    // Handshake control
    always_comb
    begin
        busy_next = busy_reg;
        if (req_xfer)
            busy_next = 1'b1;
        else if (load_out)
            busy_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

@@ design/xlb_cell.sv @@
// xlb_cell: one basis slot of the cell chain. Holds one entry, reduces the
// passing value against it and folds it into the greedy maximum.
// Depends on xlb_pkg.

module xlb_cell
    import xlb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,        // chain shifts this cycle
    input  count_t idx,        // position of this cell in the chain
    input  count_t count,      // current number of stored entries
    input  tok_t   tok_in,
    output tok_t   tok_out
);

    value_t entry_reg;
    value_t entry_next;
    logic   vld_reg;
    tok_t   pay_reg;
    tok_t   pay_next;

    logic   active;
    logic   append;
    value_t v_x;
    value_t a_x;
    value_t a_new;

    // Slot in use, or the slot that takes the next new entry
    assign active = (idx < count);
    assign append = tok_in.vld && (tok_in.op == FN_INSERT) && (idx == count)
                    && (tok_in.v != '0);

    // Reduce / maximize against the stored entry or the one being appended
    always_comb
    begin
        v_x        = tok_in.v ^ entry_reg;
        a_new      = tok_in.acc ^ tok_in.v;
        a_x        = tok_in.acc ^ entry_reg;
        pay_next   = tok_in;
        entry_next = entry_reg;
        if (active)
        begin
            if (v_x < tok_in.v)
                pay_next.v = v_x;
            if (a_x > tok_in.acc)
                pay_next.acc = a_x;
        end
        else if (append)
        begin
            entry_next   = tok_in.v;
            pay_next.ins = 1'b1;
            if (a_new > tok_in.acc)
                pay_next.acc = a_new;
        end
    end

    // Token valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= tok_in.vld;
    end

    // Token payload and stored entry
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg   <= pay_next;
            entry_reg <= entry_next;
        end
    end

    always_comb
    begin
        tok_out     = pay_reg;
        tok_out.vld = vld_reg;
    end

endmodule
